// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the sensor compensation block
// Register indexes, field widths and small helpers for 32-bit wrapped math.
// ----------------------------------------------------------------------------
`default_nettype none
package esc_pkg;
   localparam int RegCount    = 6;
   localparam int CsrAddrW    = 6;
   localparam int DivStages   = 32;

   typedef enum logic [2:0] {
      REG_TEMP      = 3'd0,
      REG_PRESS_LO  = 3'd1,
      REG_PRESS_MID = 3'd2,
      REG_PRESS_HI  = 3'd3,
      REG_HUM_LO    = 3'd4,
      REG_HUM_HI    = 3'd5
   } reg_idx_type;

   localparam logic [31:0] FineOffsetP = 32'd64000;
   localparam logic [31:0] Round32768  = 32'd32768;
   localparam logic [31:0] PressBase   = 32'd1048576;
   localparam logic [31:0] PressScale  = 32'd3125;
   localparam logic [31:0] SignBit     = 32'h8000_0000;
   localparam logic [31:0] FineOffsetH = 32'd76800;
   localparam logic [31:0] Round16384  = 32'd16384;
   localparam logic [31:0] HumBias     = 32'd2097152;
   localparam logic [31:0] Round8192   = 32'd8192;
   localparam logic [31:0] HumMax      = 32'd419430400;

   function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction
endpackage
`default_nettype wire

// ===== rtl/esc_divider.sv =====
// ----------------------------------------------------------------------------
// esc_divider: pipelined restoring divider
// Unsigned 32 by 32 division, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
`default_nettype none
module esc_divider
   import esc_pkg::*;
#(
   parameter int SideW = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [31:0]      in_num,
   input  wire logic [31:0]      in_den,
   input  wire logic [SideW-1:0] in_side,
   output logic                  out_valid,
   output logic [31:0]           out_quot,
   output logic [SideW-1:0]      out_side
);
   logic [DivStages:0]     vld_ff;
   logic [31:0]            num_ff  [DivStages+1];
   logic [31:0]            rem_ff  [DivStages+1];
   logic [31:0]            den_ff  [DivStages+1];
   logic [SideW-1:0]       side_ff [DivStages+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      num_ff[0]  = in_num;
      rem_ff[0]  = '0;
      den_ff[0]  = in_den;
      side_ff[0] = in_side;
   end

   for (genvar s = 0; s < DivStages; s++) begin : g_st
      logic [32:0] trial;
      logic [32:0] diff;
      assign trial = {rem_ff[s], num_ff[s][31]};
      assign diff  = trial - {1'b0, den_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (en) begin
            // quotient bits shift into the numerator word
            if (!diff[32]) begin
               rem_ff[s+1] <= diff[31:0];
               num_ff[s+1] <= {num_ff[s][30:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial[31:0];
               num_ff[s+1] <= {num_ff[s][30:0], 1'b0};
            end
            den_ff[s+1]  <= den_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[DivStages];
   assign out_quot  = num_ff[DivStages];
   assign out_side  = side_ff[DivStages];
endmodule
`default_nettype wire

// ===== rtl/env_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation: integer temperature, pressure, humidity compensation
// Pipelined 32-bit wrapped compensation of one raw measurement per cycle while not stalled.
// ----------------------------------------------------------------------------
// usage
//   req_* channel carries raw temperature, pressure and humidity words, rsp_*
//   returns temperature in 0.01 degC, pressure in Pa and humidity in Q7.10.
//   the user must write calibration coefficients through the csr_ APB-style
//   port at byte addresses 8*i only while the block is idle; it is not enforced.
// timing
//   one request is taken per cycle while the pipeline is not stalled; a request
//   passes through 22 front stages (arithmetic in the first 13, the rest only
//   carry data), the 32-stage divider for the pressure quotient, 4 pressure
//   correction stages and the output register.
// reset
//   synchronous reset clears all valid bits and coefficient registers.
// stall
//   when the output register is full and rsp_ready is low the whole pipeline
//   holds; req_ready drops only while the output register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none
module env_sensor_compensation
   import esc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [19:0]         req_raw_temperature,
   input  wire logic [19:0]         req_raw_pressure,
   input  wire logic [15:0]         req_raw_humidity,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_temperature_centi,
   output logic [31:0]              rsp_pressure_pa,
   output logic [16:0]              rsp_humidity_q10,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [63:0]         csr_pwdata,
   output logic [63:0]              csr_prdata,
   output logic                     csr_pready
);
   localparam int NPre = 22;
   localparam int NPost = 4;
   localparam int SideW = 32 + 17 + 1 + 32 * 3 + 1;

   // ---------------- registers
   logic [47:0] tc_ff, plo_ff, pmid_ff, phi_ff;
   logic [31:0] hlo_ff;
   logic [39:0] hhi_ff;
   reg_idx_type widx;
   assign widx = reg_idx_type'(csr_paddr[5:3]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0; plo_ff <= '0; pmid_ff <= '0; phi_ff <= '0;
         hlo_ff <= '0; hhi_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (widx)
            REG_TEMP:      tc_ff   <= csr_pwdata[47:0];
            REG_PRESS_LO:  plo_ff  <= csr_pwdata[47:0];
            REG_PRESS_MID: pmid_ff <= csr_pwdata[47:0];
            REG_PRESS_HI:  phi_ff  <= csr_pwdata[47:0];
            REG_HUM_LO:    hlo_ff  <= csr_pwdata[31:0];
            REG_HUM_HI:    hhi_ff  <= csr_pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_TEMP:      csr_prdata = {16'd0, tc_ff};
         REG_PRESS_LO:  csr_prdata = {16'd0, plo_ff};
         REG_PRESS_MID: csr_prdata = {16'd0, pmid_ff};
         REG_PRESS_HI:  csr_prdata = {16'd0, phi_ff};
         REG_HUM_LO:    csr_prdata = {32'd0, hlo_ff};
         REG_HUM_HI:    csr_prdata = {24'd0, hhi_ff};
         default:       csr_prdata = '0;
      endcase
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;
   assign t1 = {16'd0, tc_ff[15:0]};
   assign t2 = sx16(tc_ff[31:16]);
   assign t3 = sx16(tc_ff[47:32]);
   assign p1 = {16'd0, plo_ff[15:0]};
   assign p2 = sx16(plo_ff[31:16]);
   assign p3 = sx16(plo_ff[47:32]);
   assign p4 = sx16(pmid_ff[15:0]);
   assign p5 = sx16(pmid_ff[31:16]);
   assign p6 = sx16(pmid_ff[47:32]);
   assign p7 = sx16(phi_ff[15:0]);
   assign p8 = sx16(phi_ff[31:16]);
   assign p9 = sx16(phi_ff[47:32]);
   assign h1 = {24'd0, hlo_ff[7:0]};
   assign h2 = sx16(hlo_ff[23:8]);
   assign h3 = {24'd0, hlo_ff[31:24]};
   assign h4 = sx16(hhi_ff[15:0]);
   assign h5 = sx16(hhi_ff[31:16]);
   assign h6 = {{24{hhi_ff[39]}}, hhi_ff[39:32]};

   // ---------------- pipeline control
   logic en;
   logic out_full_ff;
   assign en = !out_full_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- front pipeline: 22 stages, arithmetic in the first 13
   typedef struct packed {
      logic [19:0] ap;
      logic [15:0] ah;
      logic [31:0] tr;   // working temperature-side word
      logic [31:0] fine;
      logic [31:0] temp;
      logic [31:0] a;
      logic [31:0] sq;
      logic [31:0] b;
      logic [31:0] pa;
      logic [31:0] pn;
      logic [31:0] x;
      logic [31:0] lft;
      logic [31:0] m;
      logic [31:0] u;
      logic [31:0] w;
      logic [31:0] hx;
   } st_type;

   logic   [NPre:0] v_ff;
   st_type s_ff [NPre+1];
   st_type s_in [NPre];

   always_comb begin
      v_ff[0] = req_valid;
      s_ff[0] = '0;
      s_ff[0].ap = req_raw_pressure;
      s_ff[0].ah = req_raw_humidity;
      s_ff[0].tr = {12'd0, req_raw_temperature};
   end

   always_comb begin
      for (int k = 0; k < NPre; k++) s_in[k] = s_ff[k];
      // 0: v1 term
      s_in[0].u  = asr(mulw((s_ff[0].tr >> 3) - (t1 << 1), t2), 11);
      s_in[0].w  = (s_ff[0].tr >> 4) - t1;
      // 1: d*d
      s_in[1].w  = asr(mulw(s_ff[1].w, s_ff[1].w), 12);
      // 2: fine
      s_in[2].fine = s_ff[2].u + asr(mulw(s_ff[2].w, t3), 14);
      // 3: temp, pressure a, humidity x
      s_in[3].temp = asr(mulw(s_ff[3].fine, 32'd5) + 32'd128, 8);
      s_in[3].a    = asr(s_ff[3].fine, 1) - FineOffsetP;
      s_in[3].x    = s_ff[3].fine - FineOffsetH;
      // 4: sq and humidity left multiply
      s_in[4].sq  = mulw(asr(s_ff[4].a, 2), asr(s_ff[4].a, 2));
      s_in[4].lft = mulw(h5, s_ff[4].x);
      // 5: b first term, humidity lft
      s_in[5].b   = mulw(asr(s_ff[5].sq, 11), p6);
      s_in[5].lft = asr((({16'd0, s_ff[5].ah} << 14) - (h4 << 20) - s_ff[5].lft)
                        + Round16384, 15);
      s_in[5].u   = asr(mulw(s_ff[5].x, h6), 10);
      // 6: b add, humidity h3 term
      s_in[6].b = s_ff[6].b + (mulw(s_ff[6].a, p5) << 1);
      s_in[6].w = asr(mulw(s_ff[6].x, h3), 11) + Round32768;
      // 7: b final, p3 term
      s_in[7].b  = asr(s_ff[7].b, 2) + (p4 << 16);
      s_in[7].pa = asr(mulw(p3, asr(s_ff[7].sq, 13)), 3);
      s_in[7].m  = asr(mulw(s_ff[7].u, s_ff[7].w), 10) + HumBias;
      // 8: p2 term
      s_in[8].pa = asr(s_ff[8].pa + asr(mulw(p2, s_ff[8].a), 1), 18);
      s_in[8].m  = asr(mulw(s_ff[8].m, h2) + Round8192, 14);
      // 9: divisor
      s_in[9].pa = asr(mulw(Round32768 + s_ff[9].pa, p1), 15);
      s_in[9].hx = mulw(s_ff[9].lft, s_ff[9].m);
      // 10: numerator
      s_in[10].pn = mulw((PressBase - {12'd0, s_ff[10].ap}) - asr(s_ff[10].b, 12),
                         PressScale);
      s_in[10].u  = asr(s_ff[10].hx, 15);
      // 11: y*y
      s_in[11].u = asr(mulw(s_ff[11].u, s_ff[11].u), 7);
      // 12: humidity final
      begin
         logic [31:0] hv;
         hv = s_ff[12].hx - asr(mulw(s_ff[12].u, h1), 4);
         if (hv[31]) hv = '0;
         if (hv > HumMax) hv = HumMax;
         s_in[12].hx = hv;
      end
   end

   for (genvar k = 0; k < NPre; k++) begin : g_pre
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) s_ff[k+1] <= s_in[k];
      end
   end

   // ---------------- divider
   st_type      sd;
   logic [31:0] dnum;
   logic        dsmall;
   assign sd     = s_ff[NPre];
   assign dsmall = sd.pn < SignBit;
   assign dnum   = dsmall ? (sd.pn << 1) : sd.pn;

   logic [SideW-1:0] side_in, side_out;
   logic             dv;
   logic [31:0]      dq;
   assign side_in = {sd.temp, 17'(sd.hx >> 12), dsmall, p7, p8, p9,
                     (sd.pa == '0)};

   esc_divider #(.SideW(SideW)) u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v_ff[NPre]), .in_num(dnum), .in_den(sd.pa), .in_side(side_in),
      .out_valid(dv), .out_quot(dq), .out_side(side_out)
   );

   // ---------------- pressure correction
   logic [31:0] o_temp;
   logic [16:0] o_hum;
   logic        o_small;
   logic [31:0] o_p7, o_p8, o_p9;
   logic        o_zero;
   assign {o_temp, o_hum, o_small, o_p7, o_p8, o_p9, o_zero} = side_out;

   logic [NPost:0] q_v_ff;
   logic [31:0]    q_p_ff   [NPost+1];
   logic [31:0]    q_t_ff   [NPost+1];
   logic [16:0]    q_h_ff   [NPost+1];
   logic [31:0]    q_p7_ff  [NPost+1];
   logic [31:0]    q_p9_ff  [NPost+1];
   logic           q_z_ff   [NPost+1];
   logic [31:0]    psq_ff, c1_ff, c2_ff, corr_ff;

   always_comb begin
      q_v_ff[0]  = dv;
      q_p_ff[0]  = o_small ? dq : (dq << 1);
      q_t_ff[0]  = o_temp;
      q_h_ff[0]  = o_hum;
      q_p7_ff[0] = o_p7;
      q_p9_ff[0] = o_p9;
      q_z_ff[0]  = o_zero;
   end

   logic [31:0] p8_d1_ff;
   always_ff @(posedge clock) begin
      if (en) p8_d1_ff <= o_p8;
   end

   for (genvar k = 0; k < NPost; k++) begin : g_post
      always_ff @(posedge clock) begin
         if (en) begin
            q_t_ff[k+1]  <= q_t_ff[k];
            q_h_ff[k+1]  <= q_h_ff[k];
            q_p7_ff[k+1] <= q_p7_ff[k];
            q_p9_ff[k+1] <= q_p9_ff[k];
            q_z_ff[k+1]  <= q_z_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff[NPost:1] <= '0;
      end else if (en) begin
         q_v_ff[NPost:1] <= q_v_ff[NPost-1:0];
      end
      if (en) begin
         q_p_ff[1] <= q_p_ff[0];
         q_p_ff[2] <= q_p_ff[1];
         q_p_ff[3] <= q_p_ff[2];
         // square of p/8
         psq_ff <= mulw(q_p_ff[0] >> 3, q_p_ff[0] >> 3) >> 13;
         // p8 term and p9 term
         c2_ff <= asr(mulw(q_p_ff[1] >> 2, p8_d1_ff), 13);
         c1_ff <= asr(mulw(q_p9_ff[1], psq_ff), 12);
         // sum
         corr_ff <= asr(c1_ff + c2_ff + q_p7_ff[2], 4);
         q_p_ff[NPost] <= q_z_ff[3] ? '0 : q_p_ff[3] + corr_ff;
      end
   end

   // ---------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (en) begin
         out_full_ff <= q_v_ff[NPost];
      end
      if (en) begin
         rsp_temperature_centi <= q_t_ff[NPost];
         rsp_pressure_pa       <= q_p_ff[NPost];
         rsp_humidity_q10      <= q_h_ff[NPost];
      end
   end
   assign rsp_valid = out_full_ff;
endmodule
`default_nettype wire

// ===== rtl/esc_checker.sv =====
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the compensation block
// Handshake and range properties seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module esc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_pressure_pa,
   input wire logic [16:0] rsp_humidity_q10,
   input wire logic        csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressure_pa))
      else $error("result dropped under stall");
   a_hum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q10 <= 17'd102400)
      else $error("humidity beyond full scale");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
   a_rdy: assert property (@(posedge clock) csr_pready)
      else $error("csr pready low");
endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_pressure_pa(rsp_pressure_pa),
   .rsp_humidity_q10(rsp_humidity_q10), .csr_pready(csr_pready)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for env_sensor_compensation
// Drives raw measurements over the request channel, predicts the compensated
// temperature, pressure and humidity in 32-bit wrapped arithmetic, and checks
// every response in order. Coefficients are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top
   import esc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [19:0] raw_t;
      logic [19:0] raw_p;
      logic [15:0] raw_h;
   } meas_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] hum;
   } comp_type;

   localparam int PipeLatency = 59;
   localparam int WatchLimit  = 20000;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [19:0] req_raw_temperature, req_raw_pressure;
   logic [15:0] req_raw_humidity;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_pa;
   logic [16:0] rsp_humidity_q10;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [63:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   env_sensor_compensation DUT (.*);

   logic [63:0] coeff [RegCount];
   comp_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_rsp = 0;
   bit rsp_free = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] sra(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] s16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic comp_type compensate(meas_type m);
      logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] v1, v2, d, fine, a, b, sq, p, c1, c2, x, y, lft, rgt, q;
      comp_type r;
      at = {12'd0, m.raw_t};
      ap = {12'd0, m.raw_p};
      ah = {16'd0, m.raw_h};
      t1 = {16'd0, coeff[REG_TEMP][15:0]};
      t2 = s16(coeff[REG_TEMP][31:16]);
      t3 = s16(coeff[REG_TEMP][47:32]);
      p1 = {16'd0, coeff[REG_PRESS_LO][15:0]};
      p2 = s16(coeff[REG_PRESS_LO][31:16]);
      p3 = s16(coeff[REG_PRESS_LO][47:32]);
      p4 = s16(coeff[REG_PRESS_MID][15:0]);
      p5 = s16(coeff[REG_PRESS_MID][31:16]);
      p6 = s16(coeff[REG_PRESS_MID][47:32]);
      p7 = s16(coeff[REG_PRESS_HI][15:0]);
      p8 = s16(coeff[REG_PRESS_HI][31:16]);
      p9 = s16(coeff[REG_PRESS_HI][47:32]);
      h1 = {24'd0, coeff[REG_HUM_LO][7:0]};
      h2 = s16(coeff[REG_HUM_LO][23:8]);
      h3 = {24'd0, coeff[REG_HUM_LO][31:24]};
      h4 = s16(coeff[REG_HUM_HI][15:0]);
      h5 = s16(coeff[REG_HUM_HI][31:16]);
      h6 = {{24{coeff[REG_HUM_HI][39]}}, coeff[REG_HUM_HI][39:32]};

      v1 = sra(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      v2 = sra(sra(d * d, 12) * t3, 14);
      fine = v1 + v2;
      r.temp = sra(fine * 32'd5 + 32'd128, 8);

      a = sra(fine, 1) - 32'd64000;
      sq = sra(a, 2) * sra(a, 2);
      b = sra(sq, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((32'd32768 + a) * p1, 15);
      if (a == 0) begin
         p = 0;
      end else begin
         p = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
         if (p < 32'h8000_0000) p = (p << 1) / a;
         else p = (p / a) << 1;
         q = (p >> 3) * (p >> 3);
         c1 = sra(p9 * (q >> 13), 12);
         c2 = sra((p >> 2) * p8, 13);
         p = p + sra(c1 + c2 + p7, 4);
      end
      r.press = p;

      x = fine - 32'd76800;
      lft = sra(((ah << 14) - (h4 << 20) - h5 * x) + 32'd16384, 15);
      q = sra(sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
      rgt = sra(q * h2 + 32'd8192, 14);
      x = lft * rgt;
      y = sra(x, 15);
      x = x - sra(sra(y * y, 7) * h1, 4);
      if (x[31]) x = 0;
      if (x > 32'd419430400) x = 32'd419430400;
      r.hum = x[28:12];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic csr_write(reg_idx_type idx, logic [63:0] val);
      @(negedge clock);
      csr_psel = 1; csr_penable = 0; csr_pwrite = 1;
      csr_paddr = CsrAddrW'(8 * int'(idx));
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      coeff[idx] = (idx == REG_HUM_LO) ? val & 64'hFFFF_FFFF :
                   (idx == REG_HUM_HI) ? val & 64'hFF_FFFF_FFFF : val & 64'hFFFF_FFFF_FFFF;
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (PipeLatency + 4) @(posedge clock);
   endtask

   // one request, expectation taken from the predictor
   task automatic send(meas_type m);
      @(negedge clock);
      req_valid = 1;
      req_raw_temperature = m.raw_t;
      req_raw_pressure = m.raw_p;
      req_raw_humidity = m.raw_h;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(compensate(m));
   endtask

   task automatic gap();
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic typical_coeffs();
      csr_write(REG_TEMP, {16'd50, 16'd26435, 16'd27504});
      csr_write(REG_PRESS_LO, {16'hF3D0, 16'hD4BD, 16'd36477});
      csr_write(REG_PRESS_MID, {16'hFFF9, 16'h0118, 16'd2855});
      csr_write(REG_PRESS_HI, {16'd6000, 16'hD5E8, 16'd15500});
      csr_write(REG_HUM_LO, {8'd0, 16'd361, 8'd75});
      csr_write(REG_HUM_HI, {8'd30, 16'd50, 16'd321});
   endtask

   task automatic random_coeffs();
      for (int i = 0; i < RegCount; i++)
         csr_write(reg_idx_type'(i), {$urandom, $urandom});
   endtask

   task automatic random_burst(int count);
      meas_type m;
      int n = 0;
      while (n < count) begin
         int len = $urandom_range(1, 30);
         for (int k = 0; k < len && n < count; k++, n++) begin
            case ($urandom_range(0, 3))
               0: m = {20'($urandom), 20'($urandom), 16'($urandom)};
               1: m = {20'($urandom_range(400000, 600000)),
                       20'($urandom_range(250000, 450000)), 16'($urandom_range(20000, 40000))};
               2: m = {($urandom & 1) ? 20'hFFFFF : 20'd0, 20'($urandom),
                       ($urandom & 1) ? 16'hFFFF : 16'd0};
               default: m = {20'($urandom_range(480000, 540000)), 20'($urandom),
                             16'($urandom)};
            endcase
            send(m);
         end
         gap();
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   // receiver stall pattern, with one long hold-off on request
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_ready = 0;
         else if (rsp_free) rsp_ready = 1;
         else rsp_ready = ($urandom_range(0, 3) != 0);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_temperature_centi, '0);
         end else begin
            comp_type e;
            e = expected_q.pop_front();
            if (rsp_temperature_centi !== e.temp)
               report_mismatch("temperature", rsp_temperature_centi, e.temp);
            if (rsp_pressure_pa !== e.press)
               report_mismatch("pressure", rsp_pressure_pa, e.press);
            if (rsp_humidity_q10 !== e.hum)
               report_mismatch("humidity", {15'd0, rsp_humidity_q10}, {15'd0, e.hum});
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || hold_rsp)
         idle_cycles <= 0;
      else if (expected_q.size() != 0 || req_valid)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   meas_type dir_tab [] = '{
      '{20'd0, 20'd0, 16'd0},
      '{20'hFFFFF, 20'hFFFFF, 16'hFFFF},
      '{20'hFFFFF, 20'd0, 16'd0},
      '{20'd0, 20'hFFFFF, 16'hFFFF},
      '{20'd519888, 20'd415148, 16'd30000},
      '{20'd500000, 20'd300000, 16'd0},
      '{20'd500000, 20'd300000, 16'hFFFF},
      '{20'h55555, 20'hAAAAA, 16'h5555},
      '{20'hAAAAA, 20'h55555, 16'hAAAA}
   };

   initial begin
      reset = 1;
      req_valid = 0;
      req_raw_temperature = 0; req_raw_pressure = 0; req_raw_humidity = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      for (int i = 0; i < RegCount; i++) coeff[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // all coefficients zero: divisor is zero, so pressure must read 0
      foreach (dir_tab[i]) begin
         send(dir_tab[i]);
         if (expected_q[$].press !== 0) report_mismatch("zero-divisor pressure",
            expected_q[$].press, 0);
      end
      gap();
      drain();

      typical_coeffs();
      foreach (dir_tab[i]) send(dir_tab[i]);
      gap();
      drain();

      // extremes of every coefficient
      for (int i = 0; i < RegCount; i++) csr_write(reg_idx_type'(i), '1);
      foreach (dir_tab[i]) send(dir_tab[i]);
      gap();
      drain();

      // long receiver hold-off so the pipeline fills and stalls its input
      typical_coeffs();
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         random_burst(120);
      join
      gap();
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 2 == 0) typical_coeffs();
         else random_coeffs();
         rsp_free = (ph == 2);
         random_burst(230);
         gap();
         drain();
      end
      rsp_free = 0;

      if (errors == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
